>>> sv/assert_macros.svh
// Assertion macros shared by the line pattern matcher modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/lpm_pkg.sv
// Shared constants, types and functions of the line pattern matcher.
package lpm_pkg;

   localparam int MAX_PATTERN = 16;
   localparam int MAX_COLUMN  = 4096;
   localparam int HIST_DEPTH  = MAX_PATTERN - 1;
   localparam int COL_W       = $clog2(MAX_COLUMN);
   localparam int LEN_W       = 5;
   localparam int LINE_W      = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAT_LOW  = 2'd0,
      CSR_PAT_HIGH = 2'd1,
      CSR_PAT_LEN  = 2'd2,
      CSR_IGN_CASE = 2'd3
   } lpm_csr_index_type;

   typedef struct packed {
      logic shift;
      logic clear;
      logic ignore_case;
   } lpm_cell_ctrl_type;

   typedef struct packed {
      logic              occurrence_end;
      logic [COL_W-1:0]  occurrence_start_column;
      logic [COL_W-1:0]  byte_column;
      logic              line_done;
      logic              line_matched;
      logic [LINE_W-1:0] line_index;
   } lpm_result_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ignore_case);
      logic [7:0] r;
      r = c;
      if (ignore_case && c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

>>> sv/line_pattern_matcher_top.sv
// Top level of the line pattern matcher: configuration, cell chain and line state.
// Usage:
// The request channel carries one text byte per transfer with a flag on the last
// byte of each line. Each transfer produces exactly one result transfer on the
// response channel: whether a leftmost non-overlapping occurrence of the pattern
// ends at this byte and its start column, the byte's column, the line-end echo,
// whether the line matched (on line end) and the line number.
// A row of 15 history cells shifts the line's bytes along; every cell compares
// its byte with the pattern byte for its distance, so one byte per cycle is
// taken unless requests are stalled, and each result passes through a register.
// Results pass an output register backed by a one-entry skid stage, so the
// block keeps taking bytes while a result waits; it stalls requests only when
// both are full.
// The configuration channel is always ready and writes one register per
// transfer; write it only while no byte is in flight.
// Synchronous reset clears history, counters, the pattern to zero, the
// pattern length to one and case folding off.
`include "assert_macros.svh"
module line_pattern_matcher_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_char_byte,
   input  logic                            req_end_of_line,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_occurrence_end,
   output logic [lpm_pkg::COL_W-1:0]       rsp_occurrence_start_column,
   output logic [lpm_pkg::COL_W-1:0]       rsp_byte_column,
   output logic                            rsp_line_done,
   output logic                            rsp_line_matched,
   output logic [lpm_pkg::LINE_W-1:0]      rsp_line_index,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lpm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lpm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import lpm_pkg::*;

   logic [CSR_DATA_W-1:0] pat_low_ff, pat_low_in;
   logic [CSR_DATA_W-1:0] pat_high_ff, pat_high_in;
   logic [LEN_W-1:0]      pat_len_ff, pat_len_in;
   logic                  ign_case_ff, ign_case_in;

   logic [COL_W-1:0]      col_ff, col_in;
   logic [COL_W-1:0]      nas_ff, nas_in;
   logic                  has_ff, has_in;
   logic [LINE_W-1:0]     line_ff, line_in;

   logic [2*CSR_DATA_W-1:0] pat_all;
   logic [LEN_W-1:0]      eff_len;
   logic [7:0]            aligned [MAX_PATTERN];
   logic                  active [MAX_PATTERN];
   logic [LEN_W-1:0]      pidx [MAX_PATTERN];
   logic [7:0]            chain [HIST_DEPTH+1];
   logic [HIST_DEPTH-1:0] cell_match;
   logic                  cur_match;
   logic [COL_W:0]        col_plus1;
   logic [COL_W-1:0]      start_col;
   logic                  hit;
   logic                  occ_accept;
   logic                  item_accept;
   logic                  csr_write;
   lpm_cell_ctrl_type     cell_ctrl;
   lpm_result_type        result;
   lpm_result_type        rsp_data;
   logic                  buf_stall;

   assign csr_ready   = 1'b1;
   assign csr_write   = csr_valid && csr_ready;
   assign req_stall   = buf_stall;
   assign item_accept = req_valid && !req_stall;

   always_comb begin
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      pat_len_in  = pat_len_ff;
      ign_case_in = ign_case_ff;
      if (csr_write) begin
         unique case (lpm_csr_index_type'(csr_index))
            CSR_PAT_LOW:  pat_low_in  = csr_data;
            CSR_PAT_HIGH: pat_high_in = csr_data;
            CSR_PAT_LEN:  pat_len_in  = csr_data[LEN_W-1:0];
            CSR_IGN_CASE: ign_case_in = csr_data[0];
            default:      pat_len_in  = pat_len_ff;
         endcase
      end
   end

   assign pat_all = {pat_high_ff, pat_low_ff};
   assign eff_len = (pat_len_ff > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len_ff;

   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         pidx[k]    = eff_len - LEN_W'(k) - LEN_W'(1);
         active[k]  = LEN_W'(k) < eff_len;
         aligned[k] = pat_all[8*pidx[k][$clog2(MAX_PATTERN)-1:0] +: 8];
      end
   end

   assign cell_ctrl.shift       = item_accept && !req_end_of_line;
   assign cell_ctrl.clear       = item_accept && req_end_of_line;
   assign cell_ctrl.ignore_case = ign_case_ff;

   assign chain[0] = req_char_byte;

   for (genvar j = 0; j < HIST_DEPTH; j++) begin : g_cell
      lpm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl),
         .byte_in  (chain[j]),
         .pat_byte (aligned[j+1]),
         .active   (active[j+1]),
         .byte_out (chain[j+1]),
         .match    (cell_match[j])
      );
   end

   assign cur_match  = fold_byte(req_char_byte, ign_case_ff) ==
                       fold_byte(aligned[0], ign_case_ff);
   assign col_plus1  = {1'b0, col_ff} + (COL_W+1)'(1);
   assign start_col  = COL_W'(col_plus1 - (COL_W+1)'(eff_len));
   assign hit        = (eff_len != '0) && (col_plus1 >= (COL_W+1)'(eff_len)) &&
                       cur_match && (&cell_match);
   assign occ_accept = hit && (start_col >= nas_ff);

   always_comb begin
      col_in  = col_ff;
      nas_in  = nas_ff;
      has_in  = has_ff;
      line_in = line_ff;
      if (item_accept) begin
         if (req_end_of_line) begin
            col_in  = '0;
            nas_in  = '0;
            has_in  = 1'b0;
            line_in = (line_ff != '1) ? line_ff + LINE_W'(1) : line_ff;
         end else begin
            has_in = has_ff || hit;
            if (col_plus1 < (COL_W+1)'(MAX_COLUMN)) begin
               col_in = col_plus1[COL_W-1:0];
            end
            if (occ_accept) begin
               nas_in = (col_plus1 < (COL_W+1)'(MAX_COLUMN)) ? col_plus1[COL_W-1:0] :
                        COL_W'(MAX_COLUMN - 1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= LEN_W'(1);
         ign_case_ff <= 1'b0;
         col_ff      <= '0;
         nas_ff      <= '0;
         has_ff      <= 1'b0;
         line_ff     <= '0;
      end else begin
         pat_low_ff  <= pat_low_in;
         pat_high_ff <= pat_high_in;
         pat_len_ff  <= pat_len_in;
         ign_case_ff <= ign_case_in;
         col_ff      <= col_in;
         nas_ff      <= nas_in;
         has_ff      <= has_in;
         line_ff     <= line_in;
      end
   end

   always_comb begin
      result.occurrence_end          = occ_accept;
      result.occurrence_start_column = occ_accept ? start_col : '0;
      result.byte_column             = col_ff;
      result.line_done               = req_end_of_line;
      result.line_matched            = req_end_of_line && (has_ff || hit);
      result.line_index              = line_ff;
   end

   lpm_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (result),
      .in_stall  (buf_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

   assign rsp_occurrence_end          = rsp_data.occurrence_end;
   assign rsp_occurrence_start_column = rsp_data.occurrence_start_column;
   assign rsp_byte_column             = rsp_data.byte_column;
   assign rsp_line_done               = rsp_data.line_done;
   assign rsp_line_matched            = rsp_data.line_matched;
   assign rsp_line_index              = rsp_data.line_index;

   `LPM_ASSERT_NEXT(a_line_end_clears, clock, reset, item_accept && req_end_of_line, (col_ff == '0) && (nas_ff == '0) && !has_ff, "Line state was not cleared after a line end.")
   `LPM_ASSERT_NEXT(a_accept_marks_line, clock, reset, item_accept && occ_accept && !req_end_of_line, has_ff && (nas_ff > $past(start_col) || nas_ff == COL_W'(MAX_COLUMN - 1)), "An accepted occurrence did not update the line state.")

endmodule

>>> sv/lpm_cell.sv
// One history cell: holds a past byte of the line and compares it with its pattern byte.
module lpm_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  lpm_pkg::lpm_cell_ctrl_type ctrl,
   input  logic [7:0]                 byte_in,
   input  logic [7:0]                 pat_byte,
   input  logic                       active,
   output logic [7:0]                 byte_out,
   output logic                       match
);
   import lpm_pkg::*;

   logic [7:0] hist_ff;
   logic [7:0] hist_in;

   always_comb begin
      hist_in = hist_ff;
      if (ctrl.clear) begin
         hist_in = '0;
      end else if (ctrl.shift) begin
         hist_in = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else begin
         hist_ff <= hist_in;
      end
   end

   assign byte_out = hist_ff;
   assign match    = !active ||
                     (fold_byte(hist_ff, ctrl.ignore_case) == fold_byte(pat_byte, ctrl.ignore_case));

endmodule

>>> sv/lpm_out_buf.sv
// Output register with a skid stage between the compare logic and the result channel.
`include "assert_macros.svh"
module lpm_out_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  lpm_pkg::lpm_result_type in_data,
   output logic                    in_stall,
   output logic                    out_valid,
   output lpm_pkg::lpm_result_type out_data,
   input  logic                    out_stall
);
   import lpm_pkg::*;

   logic           main_valid_ff, main_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   lpm_result_type main_data_ff, main_data_in;
   lpm_result_type skid_data_ff, skid_data_in;
   logic           take_in;
   logic           main_free;

   assign in_stall  = skid_valid_ff;
   assign take_in   = in_valid && !skid_valid_ff;
   assign main_free = !main_valid_ff || !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (main_free) begin
         main_valid_in = skid_valid_ff || take_in;
         main_data_in  = skid_valid_ff ? skid_data_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (take_in) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   `LPM_ASSERT_NOW(a_skid_needs_main, clock, reset, skid_valid_ff, main_valid_ff, "Skid stage holds a result while the output register is empty.")
   `LPM_ASSERT_NEXT(a_stalled_kept, clock, reset, main_valid_ff && out_stall, main_valid_ff, "A stalled result was dropped.")

endmodule
